FILE: src/msbt_pkg.sv
// ----------------------------------------------------------------------------
// msbt_pkg
// Shared constants, codes and control types of the mark/sweep block table.
// ----------------------------------------------------------------------------
package msbt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  // stored entry: id above the in-use mark
  localparam int ENTRY_W  = ID_W + 1;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_COLLECT = 2'd2;
  localparam logic [1:0] OP_LIST    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic load;    // latch the accepted command
    logic alloc;   // perform the append and emit its beat
    logic walk;    // table walk is running
    logic finish;  // emit the closing beat of a walk
  } msbt_cmd_t;

  typedef struct packed {
    logic op_alloc;
    logic out_free;
    logic walk_idle;
    logic hit_done;
    logic need_final;
  } msbt_sts_t;

endpackage

FILE: src/msbt_if.sv
// ----------------------------------------------------------------------------
// msbt_in_if / msbt_out_if
// Valid/ready channels for commands and result beats.
// ----------------------------------------------------------------------------
interface msbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] block_id;

  modport source (output valid, output opcode, output block_id, input ready);
  modport sink   (input valid, input opcode, input block_id, output ready);
endinterface

interface msbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] reported_id;
  logic        in_use_flag;
  logic        last_result;

  modport source (output valid, output status, output reported_id,
                  output in_use_flag, output last_result, input ready);
  modport sink   (input valid, input status, input reported_id,
                  input in_use_flag, input last_result, output ready);
endinterface

FILE: src/msbt_ram.sv
// ----------------------------------------------------------------------------
// msbt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the read word while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/msbt_ctrl.sv
// ----------------------------------------------------------------------------
// msbt_ctrl
// Command sequencer: accept, dispatch, walk the table, close the command.
// ----------------------------------------------------------------------------
module msbt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msbt_pkg::msbt_sts_t  sts,
  output msbt_pkg::msbt_cmd_t  cmd
);
  import msbt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = sts.op_alloc ? S_ALLOC : S_WALK;
      end
      S_ALLOC: begin
        if (sts.out_free) begin
          cmd.alloc = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.hit_done) begin
          state_nxt = S_IDLE;
        end else if (sts.walk_idle) begin
          state_nxt = sts.need_final ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/msbt_dp.sv
// ----------------------------------------------------------------------------
// msbt_dp
// Table datapath: entry RAM, walk pointers, pending freed id, result register.
// ----------------------------------------------------------------------------
module msbt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msbt_pkg::msbt_cmd_t  cmd,
  output msbt_pkg::msbt_sts_t  sts,
  input  logic [1:0]           in_opcode,
  input  logic [15:0]          in_block_id,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [15:0]          out_reported_id,
  output logic                 out_in_use_flag,
  output logic                 out_last_result
);
  import msbt_pkg::*;

  logic [1:0]       op_r, op_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] keep_r, keep_nxt;
  logic [IDX_W-1:0] d_idx_r, d_idx_nxt;
  logic             d_v_r, d_v_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic             out_flag_r, out_flag_nxt;
  logic             out_last_r, out_last_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    d_id;
  logic               d_mark;

  logic out_free, more, full, is_mark, is_collect, is_list;
  logic hit, step_emit, adv, list_last;

  msbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign d_id   = ram_rdata[ENTRY_W-1:1];
  assign d_mark = ram_rdata[0];

  assign out_free   = !out_valid_r || out_ready;
  assign more       = rd_idx_r < count_r;
  assign full       = count_r == CNT_W'(CAPACITY);
  assign is_mark    = op_r == OP_MARK;
  assign is_collect = op_r == OP_COLLECT;
  assign is_list    = op_r == OP_LIST;
  assign hit        = is_mark && d_v_r && (d_id == id_r);
  assign list_last  = (CNT_W'(d_idx_r) + CNT_W'(1)) == count_r;
  assign step_emit  = d_v_r && (hit || (is_collect && !d_mark && pend_v_r) || is_list);
  // a step that must emit waits for the result register
  assign adv        = cmd.walk && (!step_emit || out_free);
  assign ram_re     = adv && more && !hit;

  assign sts.op_alloc   = op_r == OP_ALLOC;
  assign sts.out_free   = out_free;
  assign sts.walk_idle  = !d_v_r && !more;
  assign sts.hit_done   = adv && hit;
  assign sts.need_final = !(is_list && (count_r != '0));

  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    keep_nxt       = keep_r;
    d_idx_nxt      = d_idx_r;
    d_v_nxt        = d_v_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_flag_nxt   = out_flag_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[IDX_W-1:0];
    ram_wdata      = {id_r, 1'b1};

    if (cmd.load) begin
      op_nxt     = in_opcode;
      id_nxt     = in_block_id;
      rd_idx_nxt = '0;
      keep_nxt   = '0;
      d_v_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.alloc) begin
      out_valid_nxt  = 1'b1;
      out_id_nxt     = id_r;
      out_last_nxt   = 1'b1;
      if (full) begin
        out_status_nxt = ST_FULL;
        out_flag_nxt   = 1'b0;
      end else begin
        ram_we         = 1'b1;
        count_nxt      = count_r + CNT_W'(1);
        out_status_nxt = ST_OK;
        out_flag_nxt   = 1'b1;
      end
    end

    if (adv) begin
      if (ram_re) begin
        d_idx_nxt  = rd_idx_r[IDX_W-1:0];
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
      end
      d_v_nxt = ram_re;
      if (d_v_r) begin
        if (hit) begin
          // clear the mark of the oldest match and stop
          ram_we         = 1'b1;
          ram_waddr      = d_idx_r;
          ram_wdata      = {d_id, 1'b0};
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_id_nxt     = id_r;
          out_flag_nxt   = 1'b0;
          out_last_nxt   = 1'b1;
        end else if (is_list) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_id_nxt     = d_id;
          out_flag_nxt   = d_mark;
          out_last_nxt   = list_last;
        end else if (is_collect) begin
          if (d_mark) begin
            // compact: move the live entry down to the keep pointer
            ram_we    = 1'b1;
            ram_waddr = keep_r[IDX_W-1:0];
            ram_wdata = {d_id, 1'b1};
            keep_nxt  = keep_r + CNT_W'(1);
          end else begin
            // hold each freed id until the next one shows it is not last
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_id_nxt     = pend_id_r;
              out_flag_nxt   = 1'b0;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = d_id;
          end
        end
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_flag_nxt  = 1'b0;
      out_last_nxt  = 1'b1;
      if (is_collect) begin
        count_nxt = keep_r;
      end
      if (is_collect && pend_v_r) begin
        out_status_nxt = ST_OK;
        out_id_nxt     = pend_id_r;
      end else if (is_mark) begin
        out_status_nxt = ST_NOT_FOUND;
        out_id_nxt     = id_r;
      end else begin
        out_status_nxt = ST_EMPTY;
        out_id_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      d_v_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      d_v_r       <= d_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    rd_idx_r     <= rd_idx_nxt;
    keep_r       <= keep_nxt;
    d_idx_r      <= d_idx_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_flag_r   <= out_flag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_reported_id = out_id_r;
  assign out_in_use_flag = out_flag_r;
  assign out_last_result = out_last_r;

endmodule

FILE: src/mark_sweep_block_table.sv
// ----------------------------------------------------------------------------
// mark_sweep_block_table
// Ordered table of block ids with in-use marks: allocate, mark, collect, list.
// ----------------------------------------------------------------------------
// One command is taken at a time; the next is accepted once the current one
// has put its last result beat into the output register. Mark, collect and
// list walk the table through the single read port of the entry RAM, one
// entry per cycle while the result channel does not stall: the command is
// accepted and dispatched, the first read is issued, each entry is stepped
// and the walk is seen to drain. A closing beat follows the walk for collect,
// a mark with no match and a list of an empty table. On an empty table the
// walk ends at once. Mark stops at the first match. Collect holds each freed
// id until the next one is found, so its last beat follows the end of the
// walk. A full table answers allocate with status "table full" and stays
// unchanged.
module mark_sweep_block_table (
  input  logic        clk,
  input  logic        rst_n,
  msbt_in_if.sink     in_ch,
  msbt_out_if.source  out_ch
);
  import msbt_pkg::*;

  msbt_cmd_t cmd;
  msbt_sts_t sts;

  msbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msbt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_block_id     (in_ch.block_id),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_reported_id (out_ch.reported_id),
    .out_in_use_flag (out_ch.in_use_flag),
    .out_last_result (out_ch.last_result)
  );

endmodule
